// ===== rtl/rj_pkg.sv =====
package rj_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int C1_W      = 2 * WORD_W;
  localparam int SQ_LAT    = C1_W / 2;
  localparam int DIV_QW    = WORD_W + 1;
  localparam int DIV_LAT   = DIV_QW + 1;
  localparam int NUM_W     = 112;
  localparam int DEN_W     = 96;
  localparam int PRE_LAT   = 3;
  localparam int MID_LAT   = 2;
  localparam int NSTAGE    = PRE_LAT + SQ_LAT + MID_LAT + DIV_LAT + 1;
  localparam logic [WORD_W-1:0] RADIUS_RST = 32'd429497;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
  } rj_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] range_by_px;
    logic signed [WORD_W-1:0] range_by_py;
    logic signed [WORD_W-1:0] bearing_by_px;
    logic signed [WORD_W-1:0] bearing_by_py;
    logic signed [WORD_W-1:0] rate_by_px;
    logic signed [WORD_W-1:0] rate_by_py;
    logic                     div_error;
  } rj_out_t;

  typedef struct packed {
    logic [WORD_W-1:0] pxm;
    logic [WORD_W-1:0] pym;
    logic              pxn;
    logic              pyn;
    logic [C1_W-1:0]   c1;
    logic [C1_W-1:0]   dm;
    logic              dn;
    logic              err;
  } rj_ctx_t;

  typedef struct packed {
    logic [5:0] neg;
    logic       err;
  } rj_side_t;

  function automatic logic [WORD_W-1:0] rj_sat(input logic neg, input logic ovf,
                                               input logic [DIV_QW-1:0] q);
    logic [DIV_QW-1:0] neg_q;
    logic [WORD_W-1:0] res;
    neg_q = ~q + 1'b1;
    if (neg) begin
      if (ovf || q > {1'b0, 32'h8000_0000}) res = 32'h8000_0000;
      else res = neg_q[WORD_W-1:0];
    end else begin
      if (ovf || q > {1'b0, 32'h7fff_ffff}) res = 32'h7fff_ffff;
      else res = q[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/rj_sqrt.sv =====
module rj_sqrt (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  rj_pkg::rj_ctx_t        ctx_i,
  output rj_pkg::rj_ctx_t        ctx_o,
  output logic [rj_pkg::WORD_W-1:0] root_o
);

  logic [rj_pkg::WORD_W+1:0] rem_q  [rj_pkg::SQ_LAT];
  logic [rj_pkg::WORD_W-1:0] root_q [rj_pkg::SQ_LAT];
  rj_pkg::rj_ctx_t           ctx_q  [rj_pkg::SQ_LAT];

  for (genvar k = 0; k < rj_pkg::SQ_LAT; k++) begin : g_step
    logic [rj_pkg::WORD_W+1:0] rem_in, cur, trial;
    logic [rj_pkg::WORD_W-1:0] root_in;
    rj_pkg::rj_ctx_t           ctx_in;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctx_in  = ctx_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign ctx_in  = ctx_q[k-1];
    end

    assign cur   = {rem_in[rj_pkg::WORD_W-1:0], ctx_in.c1[rj_pkg::C1_W-1-2*k -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? cur - trial : cur;
        root_q[k] <= {root_in[rj_pkg::WORD_W-2:0], ge};
        ctx_q[k]  <= ctx_in;
      end
    end
  end

  assign ctx_o  = ctx_q[rj_pkg::SQ_LAT-1];
  assign root_o = root_q[rj_pkg::SQ_LAT-1];

endmodule

// ===== rtl/rj_div.sv =====
module rj_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rj_pkg::NUM_W-1:0]  num_i,
  input  logic [rj_pkg::DEN_W-1:0]  den_i,
  output logic [rj_pkg::DIV_QW-1:0] quo_o,
  output logic                      ovf_o
);

  logic [rj_pkg::DEN_W-1:0]  rem_q [rj_pkg::DIV_LAT];
  logic [rj_pkg::DEN_W-1:0]  den_q [rj_pkg::DIV_LAT];
  logic [rj_pkg::DIV_QW-1:0] lo_q  [rj_pkg::DIV_LAT];
  logic [rj_pkg::DIV_QW-1:0] quo_q [rj_pkg::DIV_LAT];
  logic                      ovf_q [rj_pkg::DIV_LAT];

  logic [rj_pkg::NUM_W-1:0] num_hi;
  assign num_hi = num_i >> rj_pkg::DIV_QW;

  // quotient too wide for the result when the top part already holds the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_hi[rj_pkg::DEN_W-1:0];
      den_q[0] <= den_i;
      lo_q[0]  <= num_i[rj_pkg::DIV_QW-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= num_hi >= {{(rj_pkg::NUM_W-rj_pkg::DEN_W){1'b0}}, den_i};
    end
  end

  for (genvar k = 1; k < rj_pkg::DIV_LAT; k++) begin : g_step
    logic [rj_pkg::DEN_W:0] trial, diff;
    logic                   ge;

    assign trial = {rem_q[k-1], lo_q[k-1][rj_pkg::DIV_QW-k]};
    assign diff  = trial - {1'b0, den_q[k-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[rj_pkg::DEN_W-1:0] : trial[rj_pkg::DEN_W-1:0];
        den_q[k] <= den_q[k-1];
        lo_q[k]  <= lo_q[k-1];
        quo_q[k] <= quo_q[k-1] | ({{(rj_pkg::DIV_QW-1){1'b0}}, ge} << (rj_pkg::DIV_QW-k));
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[rj_pkg::DIV_LAT-1];
  assign ovf_o = ovf_q[rj_pkg::DIV_LAT-1];

endmodule

// ===== rtl/radar_jacobian.sv =====
// channel   dir  handshake              beat
// in        in   in_valid_i/in_stall_o  rj_in_t state vector
// out       out  out_valid_o/out_stall_i rj_out_t jacobian entries
// cfg       in   cfg_valid_i/cfg_ready_o 32-bit min_radius_sq
//
// one state vector enters per cycle while out_stall_i does not hold the pipeline; each result comes out of out_q
// most of the pipeline depth lies in the 32-step square root and the 34-step dividers
// the whole pipeline holds while a result waits under out_stall_i
// reset clears all valid bits and loads the default threshold
module radar_jacobian (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rj_pkg::rj_in_t           in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rj_pkg::rj_out_t          out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [rj_pkg::WORD_W-1:0] cfg_data_i
);

  localparam int W  = rj_pkg::WORD_W;
  localparam int CW = rj_pkg::C1_W;

  logic              en;
  logic [rj_pkg::NSTAGE-1:0] vld_q;
  logic [W-1:0]      thr_q;

  assign en          = !(vld_q[rj_pkg::NSTAGE-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[rj_pkg::NSTAGE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      thr_q <= rj_pkg::RADIUS_RST;
    end else begin
      if (en) vld_q <= {vld_q[rj_pkg::NSTAGE-2:0], in_valid_i};
      if (cfg_valid_i) thr_q <= cfg_data_i;
    end
  end

  // magnitudes and signs
  logic [W-1:0] pxm1_q, pym1_q, vxm1_q, vym1_q;
  logic         pxn1_q, pyn1_q, vxn1_q, vyn1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxn1_q <= in_data_i.pos_x[W-1];
      pyn1_q <= in_data_i.pos_y[W-1];
      vxn1_q <= in_data_i.vel_x[W-1];
      vyn1_q <= in_data_i.vel_y[W-1];
      pxm1_q <= in_data_i.pos_x[W-1] ? ~in_data_i.pos_x + 1'b1 : in_data_i.pos_x;
      pym1_q <= in_data_i.pos_y[W-1] ? ~in_data_i.pos_y + 1'b1 : in_data_i.pos_y;
      vxm1_q <= in_data_i.vel_x[W-1] ? ~in_data_i.vel_x + 1'b1 : in_data_i.vel_x;
      vym1_q <= in_data_i.vel_y[W-1] ? ~in_data_i.vel_y + 1'b1 : in_data_i.vel_y;
    end
  end

  // squares and cross products
  logic [CW-1:0] sqx2_q, sqy2_q, am2_q, bm2_q;
  logic [W-1:0]  pxm2_q, pym2_q;
  logic          pxn2_q, pyn2_q, an2_q, bn2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx2_q <= pxm1_q * pxm1_q;
      sqy2_q <= pym1_q * pym1_q;
      am2_q  <= vxm1_q * pym1_q;
      bm2_q  <= vym1_q * pxm1_q;
      pxm2_q <= pxm1_q;
      pym2_q <= pym1_q;
      pxn2_q <= pxn1_q;
      pyn2_q <= pyn1_q;
      an2_q  <= vxn1_q ^ pyn1_q;
      bn2_q  <= ~(vyn1_q ^ pxn1_q);
    end
  end

  // c1, cross difference, threshold test
  rj_pkg::rj_ctx_t ctx3_d, ctx3_q;

  always_comb begin
    ctx3_d     = '0;
    ctx3_d.pxm = pxm2_q;
    ctx3_d.pym = pym2_q;
    ctx3_d.pxn = pxn2_q;
    ctx3_d.pyn = pyn2_q;
    ctx3_d.c1  = sqx2_q + sqy2_q;
    if (an2_q == bn2_q) begin
      ctx3_d.dm = am2_q + bm2_q;
      ctx3_d.dn = an2_q;
    end else if (am2_q >= bm2_q) begin
      ctx3_d.dm = am2_q - bm2_q;
      ctx3_d.dn = an2_q;
    end else begin
      ctx3_d.dm = bm2_q - am2_q;
      ctx3_d.dn = bn2_q;
    end
    ctx3_d.err = (ctx3_d.c1 == '0) || (ctx3_d.c1 < {{(CW-W){1'b0}}, thr_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) ctx3_q <= ctx3_d;
  end

  rj_pkg::rj_ctx_t ctx_s;
  logic [W-1:0]    root_s;

  rj_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .ctx_i  (ctx3_q),
    .ctx_o  (ctx_s),
    .root_o (root_s)
  );

  // partial products of c3 and of the range-rate numerators
  logic [CW-1:0]   c3lo4_q, c3hi4_q, ylo4_q, yhi4_q, xlo4_q, xhi4_q;
  rj_pkg::rj_ctx_t ctx4_q;
  logic [W-1:0]    root4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3lo4_q <= ctx_s.c1[W-1:0] * root_s;
      c3hi4_q <= ctx_s.c1[CW-1:W] * root_s;
      ylo4_q  <= ctx_s.pym * ctx_s.dm[W-1:0];
      yhi4_q  <= ctx_s.pym * ctx_s.dm[CW-1:W];
      xlo4_q  <= ctx_s.pxm * ctx_s.dm[W-1:0];
      xhi4_q  <= ctx_s.pxm * ctx_s.dm[CW-1:W];
      ctx4_q  <= ctx_s;
      root4_q <= root_s;
    end
  end

  // divider operands
  logic [rj_pkg::NUM_W-1:0] num5_q [6];
  logic [rj_pkg::DEN_W-1:0] den5_q [6];
  rj_pkg::rj_side_t         side5_q;
  logic [rj_pkg::DEN_W-1:0] c3, ny, nx;

  assign c3 = {{W{1'b0}}, c3lo4_q} + {c3hi4_q, {W{1'b0}}};
  assign ny = {{W{1'b0}}, ylo4_q} + {yhi4_q, {W{1'b0}}};
  assign nx = {{W{1'b0}}, xlo4_q} + {xhi4_q, {W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en) begin
      num5_q[0] <= {{(rj_pkg::NUM_W-W-rj_pkg::FRAC_BITS){1'b0}}, ctx4_q.pxm,
                    {rj_pkg::FRAC_BITS{1'b0}}};
      num5_q[1] <= {{(rj_pkg::NUM_W-W-rj_pkg::FRAC_BITS){1'b0}}, ctx4_q.pym,
                    {rj_pkg::FRAC_BITS{1'b0}}};
      num5_q[2] <= {{(rj_pkg::NUM_W-W-2*rj_pkg::FRAC_BITS){1'b0}}, ctx4_q.pym,
                    {(2*rj_pkg::FRAC_BITS){1'b0}}};
      num5_q[3] <= {{(rj_pkg::NUM_W-W-2*rj_pkg::FRAC_BITS){1'b0}}, ctx4_q.pxm,
                    {(2*rj_pkg::FRAC_BITS){1'b0}}};
      num5_q[4] <= {ny, {rj_pkg::FRAC_BITS{1'b0}}};
      num5_q[5] <= {nx, {rj_pkg::FRAC_BITS{1'b0}}};
      den5_q[0] <= {{(rj_pkg::DEN_W-W){1'b0}}, root4_q};
      den5_q[1] <= {{(rj_pkg::DEN_W-W){1'b0}}, root4_q};
      den5_q[2] <= {{(rj_pkg::DEN_W-CW){1'b0}}, ctx4_q.c1};
      den5_q[3] <= {{(rj_pkg::DEN_W-CW){1'b0}}, ctx4_q.c1};
      den5_q[4] <= c3;
      den5_q[5] <= c3;
      side5_q.neg <= {ctx4_q.pxn ^ ~ctx4_q.dn, ctx4_q.pyn ^ ctx4_q.dn, ctx4_q.pxn,
                      ~ctx4_q.pyn, ctx4_q.pyn, ctx4_q.pxn};
      side5_q.err <= ctx4_q.err;
    end
  end

  logic [rj_pkg::DIV_QW-1:0] quo [6];
  logic [5:0]                ovf;

  for (genvar i = 0; i < 6; i++) begin : g_div
    rj_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num5_q[i]),
      .den_i (den5_q[i]),
      .quo_o (quo[i]),
      .ovf_o (ovf[i])
    );
  end

  rj_pkg::rj_side_t side_q [rj_pkg::DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side5_q;
      for (int k = 1; k < rj_pkg::DIV_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  // sign, saturation and refusal
  rj_pkg::rj_out_t  out_d, out_q;
  rj_pkg::rj_side_t side_f;
  logic [W-1:0]     val [6];

  assign side_f = side_q[rj_pkg::DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      val[i] = side_f.err ? '0 : rj_pkg::rj_sat(side_f.neg[i], ovf[i], quo[i]);
    end
    out_d.range_by_px   = val[0];
    out_d.range_by_py   = val[1];
    out_d.bearing_by_px = val[2];
    out_d.bearing_by_py = val[3];
    out_d.rate_by_px    = val[4];
    out_d.rate_by_py    = val[5];
    out_d.div_error     = side_f.err;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/rj_checker.sv =====
module rj_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input rj_pkg::rj_in_t            in_data_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input rj_pkg::rj_out_t           out_data_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [rj_pkg::WORD_W-1:0] cfg_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input is only held back by a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // refused division gives all-zero values
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.div_error |->
      out_data_o.range_by_px == '0 && out_data_o.range_by_py == '0 &&
      out_data_o.bearing_by_px == '0 && out_data_o.bearing_by_py == '0 &&
      out_data_o.rate_by_px == '0 && out_data_o.rate_by_py == '0)
    else $error("refused division with nonzero values");

  // when px/c2 is negative, px/c1 is negative or zero
  a_px_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_by_px[rj_pkg::WORD_W-1] |->
      out_data_o.bearing_by_py[rj_pkg::WORD_W-1] || out_data_o.bearing_by_py == '0)
    else $error("range and bearing partials disagree in sign");

endmodule

bind radar_jacobian rj_checker u_rj_checker (.*);
